@@ sv/abas_pkg.sv @@
`timescale 1ns / 1ps

package abas_pkg;

	// Default payload size of one data packet, in bytes
	localparam int PAYLOAD_BYTES_DEF = 20;

	// Retransmit timeout after reset, in ticks
	localparam logic [15:0] TIMEOUT_RESET = 16'd30;

	// Input item kinds
	localparam logic [1:0] FUNC_MSG  = 2'd0;
	localparam logic [1:0] FUNC_ACK  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_REFUSE = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;

	// Message gathering modes
	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_GATHER  = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  msg_byte;
		logic        msg_last;
		logic [19:0] ack_seq;
		logic [19:0] ack_num;
		logic [7:0]  ack_first_byte;
		logic [21:0] ack_checksum;
	} abas_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       pkt_seq;
		logic [8:0] pkt_checksum;
		logic [7:0] pkt_byte;
		logic       last;
	} abas_out_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic start_run;
		logic emit_single;
		logic emit_byte;
	} abas_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic launch;
		logic single;
		logic send_last;
	} abas_sts_t;

endpackage

@@ sv/abas_ctrl.sv @@
`timescale 1ns / 1ps

module abas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  abas_pkg::abas_sts_t sts,
	output abas_pkg::abas_cmd_t cmd
);
	import abas_pkg::*;

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_SEND   = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;
	logic load;

	// Output register can take a new result this cycle
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_ACCEPT) && out_free;
	assign out_valid = out_valid_q;

	// Issue commands to the datapath
	always_comb begin
		cmd.take        = in_valid && in_ready;
		cmd.start_run   = cmd.take && sts.launch;
		cmd.emit_single = cmd.take && sts.single;
		cmd.emit_byte   = (state_q == ST_SEND) && out_free;
	end

	assign load = cmd.emit_single || cmd.emit_byte;

	// Advance the state and hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCEPT: begin
					if (cmd.start_run) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (cmd.emit_byte && sts.send_last) begin
						state_q <= ST_ACCEPT;
					end
				end
				default: state_q <= ST_ACCEPT;
			endcase
		end
	end

endmodule

@@ sv/abas_dp.sv @@
`timescale 1ns / 1ps

module abas_dp #(
	parameter int PAYLOAD_BYTES = abas_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  abas_pkg::abas_in_t  item,
	input  abas_pkg::abas_cmd_t cmd,
	output abas_pkg::abas_sts_t sts,
	input  logic                cfg_wr,
	input  logic [15:0]         cfg_data,
	output abas_pkg::abas_out_t res
);
	import abas_pkg::*;

	localparam int LW = $clog2(PAYLOAD_BYTES + 1);
	localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	// Protocol state
	logic          seq_q, idle_q, trun_q;
	logic [LW-1:0] len_q, idx_q;
	logic [7:0]    rs_q;
	logic [8:0]    ck_q;
	logic [1:0]    mode_q;
	logic [15:0]   tcnt_q, tout_q;
	logic [7:0]    store_q [PAYLOAD_BYTES];

	// Next values
	logic          seq_d, idle_d, trun_d;
	logic [LW-1:0] len_d;
	logic [7:0]    rs_d;
	logic [8:0]    ck_d;
	logic [1:0]    mode_d;
	logic [15:0]   tcnt_d;
	logic          wr_en;
	abas_out_t     single_res;

	// Byte path helpers
	logic          between;
	logic [LW-1:0] len_eff, len_new;
	logic [7:0]    rs_eff, rs_new;
	logic [8:0]    sum9, fold9;
	logic [21:0]   ack_sum;
	logic          ack_ok;
	logic [15:0]   tcnt_inc;

	assign between  = (mode_q == MODE_BETWEEN);
	assign len_eff  = between ? '0 : len_q;
	assign rs_eff   = between ? 8'd0 : rs_q;
	assign len_new  = len_eff + LW'(1);
	assign sum9     = {1'b0, rs_eff} + {1'b0, item.msg_byte};
	assign fold9    = (sum9 > 9'd255) ? (sum9 - 9'd254) : sum9;
	assign rs_new   = (len_eff == '0) ? item.msg_byte : ~fold9[7:0];
	assign ack_sum  = {14'd0, item.ack_first_byte} + {2'd0, item.ack_num}
		+ {2'd0, item.ack_seq};
	assign ack_ok   = (ack_sum == item.ack_checksum) && (item.ack_num == {19'd0, seq_q});
	assign tcnt_inc = tcnt_q + 16'd1;

	// Decode the request against the protocol state
	always_comb begin
		seq_d      = seq_q;
		idle_d     = idle_q;
		len_d      = len_q;
		rs_d       = rs_q;
		ck_d       = ck_q;
		mode_d     = mode_q;
		trun_d     = trun_q;
		tcnt_d     = tcnt_q;
		wr_en      = 1'b0;
		sts.launch = 1'b0;
		sts.single = 1'b0;
		sts.send_last = (len_q == '0) || ((idx_q + LW'(1)) == len_q);
		single_res = '0;
		single_res.last = 1'b1;
		case (item.func)
			FUNC_MSG: begin
				if (between && !idle_q) begin
					// Refuse a message while a packet is outstanding
					sts.single      = 1'b1;
					single_res.kind = KIND_REFUSE;
					mode_d          = item.msg_last ? MODE_BETWEEN : MODE_DISCARD;
				end else if (mode_q inside {MODE_BETWEEN, MODE_GATHER}) begin
					mode_d = MODE_GATHER;
					len_d  = len_eff;
					rs_d   = rs_eff;
					if (item.msg_byte != 8'd0) begin
						rs_d  = rs_new;
						wr_en = 1'b1;
						len_d = len_new;
					end
					if (item.msg_byte == 8'd0 || item.msg_last
						|| len_new == LW'(PAYLOAD_BYTES)) begin
						// Seal the packet and start its run
						sts.launch = 1'b1;
						ck_d   = {1'b0, (item.msg_byte == 8'd0) ? rs_eff : rs_new}
							+ {8'd0, seq_q};
						idle_d = 1'b0;
						mode_d = item.msg_last ? MODE_BETWEEN : MODE_DISCARD;
						trun_d = 1'b1;
						tcnt_d = 16'd0;
					end
				end else if (item.msg_last) begin
					mode_d = MODE_BETWEEN;
				end
			end
			FUNC_ACK: begin
				if (!idle_q) begin
					if (ack_ok) begin
						sts.single         = 1'b1;
						single_res.kind    = KIND_ACK;
						single_res.pkt_seq = seq_q;
						seq_d  = ~seq_q;
						idle_d = 1'b1;
						trun_d = 1'b0;
						tcnt_d = 16'd0;
					end else begin
						// Resend and restart the timer
						sts.launch = 1'b1;
						trun_d     = 1'b1;
						tcnt_d     = 16'd0;
					end
				end
			end
			FUNC_TICK: begin
				if (trun_q) begin
					tcnt_d = tcnt_inc;
					if (tcnt_inc >= tout_q) begin
						sts.launch = 1'b1;
						tcnt_d     = 16'd0;
					end
				end
			end
			default: ;
		endcase
	end

	// Commit protocol state on an accepted request, take timeout writes and step the read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= 1'b0;
			idle_q <= 1'b1;
			len_q  <= '0;
			rs_q   <= 8'd0;
			ck_q   <= 9'd0;
			mode_q <= MODE_BETWEEN;
			trun_q <= 1'b0;
			tcnt_q <= 16'd0;
			idx_q  <= '0;
			tout_q <= TIMEOUT_RESET;
		end else begin
			if (cfg_wr) begin
				tout_q <= cfg_data;
			end
			if (cmd.take) begin
				seq_q  <= seq_d;
				idle_q <= idle_d;
				len_q  <= len_d;
				rs_q   <= rs_d;
				ck_q   <= ck_d;
				mode_q <= mode_d;
				trun_q <= trun_d;
				tcnt_q <= tcnt_d;
			end
			if (cmd.start_run) begin
				idx_q <= '0;
			end else if (cmd.emit_byte) begin
				idx_q <= idx_q + LW'(1);
			end
		end
	end

	// Write the payload byte
	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) begin
			store_q[len_eff[IW-1:0]] <= item.msg_byte;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			res <= single_res;
		end else if (cmd.emit_byte) begin
			res.kind         <= KIND_BYTE;
			res.pkt_seq      <= seq_q;
			res.pkt_checksum <= ck_q;
			res.pkt_byte     <= (len_q == '0) ? 8'd0 : store_q[idx_q[IW-1:0]];
			res.last         <= sts.send_last;
		end
	end

endmodule

@@ sv/alternating_bit_arq_sender_core.sv @@
`timescale 1ns / 1ps

// Channel  Signals                       Direction  Carries
// in       in_valid/in_ready/in_data     sink       byte, ack or tick request
// out      out_valid/out_ready/out_data  source     sent byte, refusal or ack result
// cfg      cfg_valid/cfg_ready/cfg_data  sink       timeout in ticks
//
// A request with at most one result is answered as it is taken; an output register holds it.
// A request that sends the stored packet then sends its n payload bytes
// (one zero byte for an empty payload): the store is read one byte per cycle while
// the output is not stalled, and no request is taken during the run. Intake also
// waits while the output is stalled.
// Reset clears all control state and loads a timeout of 30 ticks.

module alternating_bit_arq_sender_core #(
	parameter int PAYLOAD_BYTES = abas_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  abas_pkg::abas_in_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output abas_pkg::abas_out_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import abas_pkg::*;

	abas_cmd_t cmd;
	abas_sts_t sts;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	abas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	abas_dp #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.res      (out_data)
	);

endmodule

@@ dv/alternating_bit_arq_sender_core_test.sv @@
`timescale 1ns / 1ps

module alternating_bit_arq_sender_core_test;

	import abas_pkg::*;

	localparam int PAYLOAD_LEN = PAYLOAD_BYTES_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * PAYLOAD_LEN + 10;
	localparam int LONG_HOLD = 200;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 100;

	typedef enum {ACK_GOOD, ACK_BAD_SUM, ACK_BAD_NUM} ack_shape_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	abas_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	abas_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Sender state as the testbench sees it
	logic        sender_seq = 1'b0;
	logic        sender_idle = 1'b1;
	logic [7:0]  payload_store [PAYLOAD_LEN];
	int          payload_len = 0;
	logic [7:0]  running_sum = '0;
	logic [8:0]  stored_ck = '0;
	logic [1:0]  msg_mode = MODE_BETWEEN;
	logic        timer_on = 1'b0;
	logic [15:0] timer_count = '0;
	logic [15:0] timeout_ticks = TIMEOUT_RESET;

	abas_out_t   sender_results_due [$];
	int          active_requests = 0;
	int          result_count = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	int          in_gap_max = 10;
	int          out_stall_max = 10;
	bit          long_hold_req = 1'b0;

	alternating_bit_arq_sender_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Expected results of the sender

	function automatic void push_result(logic [1:0] kind, logic seq, logic [8:0] ck,
		logic [7:0] data, logic last);
		abas_out_t res;
		res.kind = kind;
		res.pkt_seq = seq;
		res.pkt_checksum = ck;
		res.pkt_byte = data;
		res.last = last;
		sender_results_due.push_back(res);
	endfunction

	// Stream the stored packet and restart the timer
	function automatic void resend_packet();
		timer_on = 1'b1;
		timer_count = '0;
		if (payload_len == 0) begin
			push_result(KIND_BYTE, sender_seq, stored_ck, 8'd0, 1'b1);
		end else begin
			for (int i = 0; i < payload_len; i++)
				push_result(KIND_BYTE, sender_seq, stored_ck, payload_store[i],
					i == payload_len - 1);
		end
	endfunction

	function automatic void launch_packet(logic msg_last);
		stored_ck = {1'b0, running_sum} + {8'd0, sender_seq};
		sender_idle = 1'b0;
		msg_mode = msg_last ? MODE_BETWEEN : MODE_DISCARD;
		resend_packet();
	endfunction

	function automatic void predict_sender(abas_in_t req);
		logic [8:0]  sum9;
		int unsigned ack_total;
		case (req.func)
		FUNC_MSG: begin
			if (msg_mode == MODE_BETWEEN) begin
				if (!sender_idle) begin
					msg_mode = req.msg_last ? MODE_BETWEEN : MODE_DISCARD;
					push_result(KIND_REFUSE, 1'b0, 9'd0, 8'd0, 1'b1);
					return;
				end
				payload_len = 0;
				running_sum = '0;
				msg_mode = MODE_GATHER;
			end else if (msg_mode != MODE_GATHER) begin
				if (req.msg_last)
					msg_mode = MODE_BETWEEN;
				return;
			end
			if (req.msg_byte == 8'd0) begin
				launch_packet(req.msg_last);
				return;
			end
			// Fold the carry back in and complement
			if (payload_len == 0) begin
				running_sum = req.msg_byte;
			end else begin
				sum9 = {1'b0, running_sum} + {1'b0, req.msg_byte};
				if (sum9 > 9'd255)
					sum9 = sum9 - 9'd254;
				running_sum = ~sum9[7:0];
			end
			payload_store[payload_len] = req.msg_byte;
			payload_len++;
			if (req.msg_last || payload_len >= PAYLOAD_LEN)
				launch_packet(req.msg_last);
		end
		FUNC_ACK: begin
			if (sender_idle)
				return;
			ack_total = 32'(req.ack_first_byte) + 32'(req.ack_num) + 32'(req.ack_seq);
			if (ack_total == 32'(req.ack_checksum)
				&& req.ack_num == {19'd0, sender_seq}) begin
				push_result(KIND_ACK, sender_seq, 9'd0, 8'd0, 1'b1);
				sender_seq = ~sender_seq;
				sender_idle = 1'b1;
				timer_on = 1'b0;
				timer_count = '0;
			end else begin
				resend_packet();
			end
		end
		FUNC_TICK: begin
			if (!timer_on)
				return;
			timer_count = timer_count + 16'd1;
			if (timer_count >= timeout_ticks)
				resend_packet();
		end
		default: ;
		endcase
	endfunction

	// Request driving

	task automatic send_request(input abas_in_t req);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!(in_valid && in_ready));
		active_requests++;
		predict_sender(req);
	endtask

	// Fill the fields that the request kind does not use with noise
	function automatic abas_in_t random_request();
		abas_in_t r;
		r.func = 2'($urandom_range(0, 3));
		r.msg_byte = 8'($urandom);
		r.msg_last = 1'($urandom);
		r.ack_seq = 20'($urandom);
		r.ack_num = 20'($urandom);
		r.ack_first_byte = 8'($urandom);
		r.ack_checksum = 22'($urandom);
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic last);
		abas_in_t r;
		r = random_request();
		r.func = FUNC_MSG;
		r.msg_byte = data;
		r.msg_last = last;
		send_request(r);
	endtask

	task automatic send_tick();
		abas_in_t r;
		r = random_request();
		r.func = FUNC_TICK;
		send_request(r);
	endtask

	task automatic send_unused();
		abas_in_t r;
		r = random_request();
		r.func = FUNC_UNUSED;
		send_request(r);
	endtask

	// Build the ACK against the current sequence bit, then spoil it if asked
	task automatic send_ack(input ack_shape_e shape);
		abas_in_t r;
		r = random_request();
		r.func = FUNC_ACK;
		r.ack_first_byte = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
		r.ack_num = {19'd0, sender_seq};
		if (shape == ACK_BAD_NUM)
			r.ack_num = r.ack_num ^ (20'd1 << $urandom_range(0, 19));
		r.ack_checksum = 22'(r.ack_first_byte) + 22'(r.ack_num) + 22'(r.ack_seq);
		if (shape == ACK_BAD_SUM)
			r.ack_checksum = r.ack_checksum ^ (22'd1 << $urandom_range(0, 21));
		send_request(r);
	endtask

	task automatic send_random_message(input int len);
		logic [7:0] data;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 23))
			0: data = 8'd0;
			1: data = 8'hFF;
			2: data = 8'h01;
			default: data = 8'($urandom_range(1, 255));
			endcase
			send_byte(data, i == len - 1);
		end
	endtask

	task automatic send_disturbance();
		case ($urandom_range(0, 4))
		0: send_ack(ACK_BAD_SUM);
		1: send_ack(ACK_BAD_NUM);
		2: send_tick();
		3: send_random_message($urandom_range(1, 3));
		default: send_unused();
		endcase
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		timeout_ticks = ticks;
	endtask

	// Drop valid, drain all results, then let any run in flight finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sender_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch on %s at result %0d: got %0h, want %0h",
				what, result_count, got, want);
	endtask

	// Stall the result channel for a random count per result, or a long hold on request
	initial begin : result_drain
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				stall = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				stall = $urandom_range(0, out_stall_max);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare each accepted result with the oldest one due
	always @(posedge clk) begin : result_check
		abas_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sender_results_due.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_data), 32'd0);
			end else begin
				want = sender_results_due.pop_front();
				if (out_data.kind !== want.kind)
					report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
				if (out_data.pkt_seq !== want.pkt_seq)
					report_mismatch("pkt_seq", 32'(out_data.pkt_seq),
						32'(want.pkt_seq));
				if (out_data.pkt_checksum !== want.pkt_checksum)
					report_mismatch("pkt_checksum", 32'(out_data.pkt_checksum),
						32'(want.pkt_checksum));
				if (out_data.pkt_byte !== want.pkt_byte)
					report_mismatch("pkt_byte", 32'(out_data.pkt_byte),
						32'(want.pkt_byte));
				if (out_data.last !== want.last)
					report_mismatch("last", 32'(out_data.last), 32'(want.last));
			end
			result_count++;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Tests

	task automatic test_directed_cases();
		// idle sender ignores ACKs, ticks and the unused code
		send_ack(ACK_GOOD);
		send_tick();
		send_unused();
		// empty payload
		send_byte(8'd0, 1'b1);
		// refuse a message while busy and drop its tail
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h34, 1'b1);
		// resend on a bad checksum and on a wrong number
		send_ack(ACK_BAD_SUM);
		send_ack(ACK_BAD_NUM);
		send_ack(ACK_GOOD);
		// carry fold on large bytes
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);
		send_ack(ACK_GOOD);
		// zero byte ends the payload early, rest of message dropped
		send_byte(8'h05, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h07, 1'b0);
		send_byte(8'h09, 1'b1);
		send_ack(ACK_GOOD);
	endtask

	task automatic test_one_tick_timeout();
		send_byte(8'hA5, 1'b1);
		send_tick();
		send_tick();
		send_ack(ACK_BAD_SUM);
		send_tick();
		send_ack(ACK_GOOD);
	endtask

	// Hold the result side off while requests keep coming
	task automatic test_output_hold_off();
		// start from an idle sender so that a full payload is gathered
		if (!sender_idle)
			send_ack(ACK_GOOD);
		in_gap_max = 0;
		long_hold_req = 1'b1;
		// full payload, then two bytes that must be dropped
		for (int i = 0; i < PAYLOAD_LEN + 2; i++)
			send_byte(8'($urandom_range(1, 255)), i == PAYLOAD_LEN + 1);
		send_random_message(3);
		send_tick();
		send_tick();
		send_tick();
		send_ack(ACK_BAD_NUM);
		send_ack(ACK_GOOD);
		in_gap_max = 10;
	endtask

	task automatic test_random_traffic(input int count);
		int goal;
		int left;
		int len;
		goal = active_requests + count;
		while (active_requests < goal) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				// full exchange: message, some trouble, then the matching ACK
				if (sender_idle) begin
					case ($urandom_range(0, 9))
					0: len = $urandom_range(18, PAYLOAD_LEN + 3);
					1: len = $urandom_range(7, 17);
					default: len = $urandom_range(1, 6);
					endcase
					send_random_message(len);
					repeat ($urandom_range(0, 3)) send_disturbance();
				end
				send_ack(ACK_GOOD);
			end
			6, 7: begin
				// run the timer out when that is affordable
				if (timer_on) begin
					left = int'(timeout_ticks - timer_count);
					if (left > 40)
						left = $urandom_range(1, 4);
					repeat (left) send_tick();
				end else begin
					send_tick();
				end
			end
			default: send_request(random_request());
			endcase
		end
	endtask

	initial begin : main
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(45);

		wait_idle();
		write_timeout(16'd1);
		test_one_tick_timeout();

		wait_idle();
		write_timeout(16'hFFFF);
		test_random_traffic(30);

		wait_idle();
		write_timeout(16'd4);
		test_output_hold_off();
		in_gap_max = 0;
		out_stall_max = 0;
		test_random_traffic(25);

		wait_idle();
		write_timeout(TIMEOUT_RESET);
		in_gap_max = 10;
		out_stall_max = 3;
		test_random_traffic(35);

		wait_idle();
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/abas_pkg.sv
sv/abas_ctrl.sv
sv/abas_dp.sv
sv/alternating_bit_arq_sender_core.sv
dv/alternating_bit_arq_sender_core_test.sv
